>>> sv/pfma_pkg.sv
// ----------------------------------------------------------------------------
// pfma_pkg: shared types and constants for the prime field modular ALU
// Operation codes, sequencer states, modular unit operations and the fixed
// field widths of the block's channels.
// ----------------------------------------------------------------------------
package pfma_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned OPND_W   = 64;
  localparam int unsigned RESULT_W = 31;
  localparam int unsigned CFG_W    = 31;

  // Modulus after reset: 1e9 + 7
  localparam logic [CFG_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Operation codes carried by the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_POW = 3'd4
  } pfma_mode_e;

  // Operations of the shared modular add/subtract unit
  typedef enum logic {
    UOP_ADD = 1'b0,
    UOP_SUB = 1'b1
  } pfma_uop_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_NEG_A,
    ST_RED_B,
    ST_NEG_B,
    ST_EXEC,
    ST_POW_STEP,
    ST_POW_ACC,
    ST_POW_NEXT,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_FIN,
    ST_DONE
  } pfma_state_e;

  // Sequencer status toward the channel logic
  typedef struct packed {
    logic ready;
    logic done;
  } pfma_stat_t;

endpackage

>>> sv/pfma_modunit.sv
// ----------------------------------------------------------------------------
// pfma_modunit: shared modular add/subtract unit
// Computes (u + v + cin) mod m or (u - v) mod m for residues u, v below m,
// with one add and one conditional correction.
// ----------------------------------------------------------------------------
module pfma_modunit
  import pfma_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  pfma_uop_e             uop_i,
  input  logic [MOD_BITS-1:0]   u_i,
  input  logic [MOD_BITS-1:0]   v_i,
  input  logic                  cin_i,
  input  logic [MOD_BITS-1:0]   m_i,
  output logic [MOD_BITS-1:0]   y_o
);

  logic [MOD_BITS:0] sum;
  logic [MOD_BITS:0] sum_red;
  logic [MOD_BITS:0] diff;
  logic [MOD_BITS:0] diff_fix;

  // Add with carry in, then fold back once
  assign sum     = {1'b0, u_i} + {1'b0, v_i} + {{MOD_BITS{1'b0}}, cin_i};
  assign sum_red = sum - {1'b0, m_i};

  // Subtract, then add the modulus back on borrow
  assign diff     = {1'b0, u_i} - {1'b0, v_i};
  assign diff_fix = diff + {1'b0, m_i};

  always_comb begin
    case (uop_i)
      UOP_ADD: y_o = (sum >= {1'b0, m_i}) ? sum_red[MOD_BITS-1:0] : sum[MOD_BITS-1:0];
      UOP_SUB: y_o = diff[MOD_BITS] ? diff_fix[MOD_BITS-1:0] : diff[MOD_BITS-1:0];
      default: y_o = '0;
    endcase
  end

endmodule

>>> sv/pfma_seq.sv
// ----------------------------------------------------------------------------
// pfma_seq: operation sequencer of the prime field modular ALU
// Reduces both operands bit by bit, then runs add, subtract, shift-and-add
// multiply, square-and-multiply power and divide on one shared modular unit.
// ----------------------------------------------------------------------------
module pfma_seq
  import pfma_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [OPND_W-1:0]   operand_a_i,
  input  logic [OPND_W-1:0]   operand_b_i,
  input  logic [MOD_BITS-1:0] modulus_i,
  input  logic                out_free_i,
  output pfma_stat_t          stat_o,
  output logic [MOD_BITS-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(OPND_W);
  localparam logic [MOD_BITS-1:0] ONE = {{(MOD_BITS-1){1'b0}}, 1'b1};
  localparam logic [MOD_BITS-1:0] TWO = MOD_BITS'(2);

  pfma_state_e         state_q, state_d;
  pfma_state_e         ret_q, ret_d;
  pfma_mode_e          mode_q, mode_d;
  logic [MOD_BITS-1:0] m_q, m_d;
  logic [OPND_W-1:0]   shift_q, shift_d;
  logic [OPND_W-1:0]   bmag_q, bmag_d;
  logic                nega_q, nega_d;
  logic                negb_q, negb_d;
  logic [MOD_BITS-1:0] a_q, a_d;
  logic [MOD_BITS-1:0] b_q, b_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] base_q, base_d;
  logic [MOD_BITS-1:0] exp_q, exp_d;
  logic [MOD_BITS-1:0] mx_q, mx_d;
  logic [MOD_BITS-1:0] my_q, my_d;
  logic [MOD_BITS-1:0] macc_q, macc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [MOD_BITS-1:0] res_q, res_d;

  pfma_uop_e           uop;
  logic [MOD_BITS-1:0] u_op;
  logic [MOD_BITS-1:0] v_op;
  logic                cin;
  logic [MOD_BITS-1:0] y;

  logic [OPND_W-1:0]   mag_a;
  logic [OPND_W-1:0]   mag_b;

  // Magnitudes of the two's complement operands
  assign mag_a = operand_a_i[OPND_W-1] ? (~operand_a_i + OPND_W'(1)) : operand_a_i;
  assign mag_b = operand_b_i[OPND_W-1] ? (~operand_b_i + OPND_W'(1)) : operand_b_i;

  // Shared modular unit
  pfma_modunit #(
    .MOD_BITS (MOD_BITS)
  ) u_modunit (
    .uop_i (uop),
    .u_i   (u_op),
    .v_i   (v_op),
    .cin_i (cin),
    .m_i   (m_q),
    .y_o   (y)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    ret_q   <= ret_d;
    mode_q  <= mode_d;
    m_q     <= m_d;
    shift_q <= shift_d;
    bmag_q  <= bmag_d;
    nega_q  <= nega_d;
    negb_q  <= negb_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    base_q  <= base_d;
    exp_q   <= exp_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    macc_q  <= macc_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  // Next state, unit operand selection and register updates
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    mode_d  = mode_q;
    m_d     = m_q;
    shift_d = shift_q;
    bmag_d  = bmag_q;
    nega_d  = nega_q;
    negb_d  = negb_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    mx_d    = mx_q;
    my_d    = my_q;
    macc_d  = macc_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    uop     = UOP_ADD;
    u_op    = '0;
    v_op    = '0;
    cin     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          mode_d  = pfma_mode_e'(mode_i);
          m_d     = modulus_i;
          shift_d = mag_a;
          bmag_d  = mag_b;
          nega_d  = operand_a_i[OPND_W-1];
          negb_d  = operand_b_i[OPND_W-1];
          a_d     = '0;
          cnt_d   = CNT_W'(OPND_W - 1);
          if (modulus_i < TWO) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RED_A;
          end
        end
      end

      // Horner reduction of operand a, one bit per cycle
      ST_RED_A: begin
        u_op    = a_q;
        v_op    = a_q;
        cin     = shift_q[OPND_W-1];
        a_d     = y;
        shift_d = {shift_q[OPND_W-2:0], 1'b0};
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_NEG_A;
        end
      end

      // Take the non-negative residue of a negative a
      ST_NEG_A: begin
        uop  = UOP_SUB;
        v_op = a_q;
        if (nega_q) begin
          a_d = y;
        end
        shift_d = bmag_q;
        b_d     = '0;
        cnt_d   = CNT_W'(OPND_W - 1);
        state_d = ST_RED_B;
      end

      ST_RED_B: begin
        u_op    = b_q;
        v_op    = b_q;
        cin     = shift_q[OPND_W-1];
        b_d     = y;
        shift_d = {shift_q[OPND_W-2:0], 1'b0};
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_NEG_B;
        end
      end

      ST_NEG_B: begin
        uop  = UOP_SUB;
        v_op = b_q;
        if (negb_q) begin
          b_d = y;
        end
        state_d = ST_EXEC;
      end

      // Dispatch on the operation
      ST_EXEC: begin
        case (mode_q)
          MODE_ADD: begin
            u_op    = a_q;
            v_op    = b_q;
            res_d   = y;
            state_d = ST_DONE;
          end
          MODE_SUB: begin
            uop     = UOP_SUB;
            u_op    = a_q;
            v_op    = b_q;
            res_d   = y;
            state_d = ST_DONE;
          end
          MODE_MUL: begin
            mx_d    = a_q;
            my_d    = b_q;
            macc_d  = '0;
            cnt_d   = CNT_W'(MOD_BITS - 1);
            ret_d   = ST_FIN;
            state_d = ST_MUL_DBL;
          end
          MODE_DIV: begin
            if (b_q == '0) begin
              res_d   = '0;
              state_d = ST_DONE;
            end else begin
              base_d  = b_q;
              exp_d   = m_q - TWO;
              acc_d   = ONE;
              state_d = ST_POW_STEP;
            end
          end
          MODE_POW: begin
            base_d  = a_q;
            exp_d   = b_q;
            acc_d   = ONE;
            state_d = ST_POW_STEP;
          end
          default: begin
            res_d   = '0;
            state_d = ST_DONE;
          end
        endcase
      end

      // One exponent bit: multiply in the base if set, then square the base
      ST_POW_STEP: begin
        macc_d = '0;
        cnt_d  = CNT_W'(MOD_BITS - 1);
        if (exp_q == '0) begin
          if (mode_q == MODE_DIV) begin
            mx_d    = a_q;
            my_d    = acc_q;
            ret_d   = ST_FIN;
            state_d = ST_MUL_DBL;
          end else begin
            res_d   = acc_q;
            state_d = ST_DONE;
          end
        end else if (exp_q[0]) begin
          mx_d    = base_q;
          my_d    = acc_q;
          ret_d   = ST_POW_ACC;
          state_d = ST_MUL_DBL;
        end else begin
          mx_d    = base_q;
          my_d    = base_q;
          ret_d   = ST_POW_NEXT;
          state_d = ST_MUL_DBL;
        end
      end

      // Keep the new accumulator; skip the squaring after the top bit
      ST_POW_ACC: begin
        acc_d = macc_q;
        if (exp_q[MOD_BITS-1:1] == '0) begin
          exp_d   = '0;
          state_d = ST_POW_STEP;
        end else begin
          mx_d    = base_q;
          my_d    = base_q;
          macc_d  = '0;
          cnt_d   = CNT_W'(MOD_BITS - 1);
          ret_d   = ST_POW_NEXT;
          state_d = ST_MUL_DBL;
        end
      end

      ST_POW_NEXT: begin
        base_d  = macc_q;
        exp_d   = exp_q >> 1;
        state_d = ST_POW_STEP;
      end

      // Shift-and-add multiply, multiplier MSB first: double
      ST_MUL_DBL: begin
        u_op   = macc_q;
        v_op   = macc_q;
        macc_d = y;
        if (my_q[MOD_BITS-1]) begin
          state_d = ST_MUL_ADD;
        end else if (cnt_q == '0) begin
          state_d = ret_q;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          my_d    = my_q << 1;
          state_d = ST_MUL_DBL;
        end
      end

      // Shift-and-add multiply: add the multiplicand
      ST_MUL_ADD: begin
        u_op   = macc_q;
        v_op   = mx_q;
        macc_d = y;
        if (cnt_q == '0) begin
          state_d = ret_q;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          my_d    = my_q << 1;
          state_d = ST_MUL_DBL;
        end
      end

      ST_FIN: begin
        res_d   = macc_q;
        state_d = ST_DONE;
      end

      // Hold the result until the output register is free
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign stat_o.ready = (state_q == ST_IDLE);
  assign stat_o.done  = (state_q == ST_DONE);
  assign result_o     = res_q;

`ifndef SYNTHESIS
  // Multiply accumulator stays a residue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_DBL || state_q == ST_MUL_ADD) |-> (macc_q < m_q))
    else $error("multiply accumulator not reduced");

  // Power loop operands stay residues
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POW_STEP) |-> (acc_q < m_q && base_q < m_q))
    else $error("power loop operand not reduced");

  // Reduced operand a is a residue while b is reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED_B) |-> (a_q < m_q))
    else $error("operand a not reduced");

  // A finished result lies below a proper modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && m_q >= TWO) |-> (res_q < m_q))
    else $error("result out of range");
`endif

endmodule

>>> sv/prime_field_modular_alu.sv
// ----------------------------------------------------------------------------
// prime_field_modular_alu: modular ALU over a prime field
// Add, subtract, multiply, divide and power of two signed 64-bit operands
// reduced mod a programmable modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: mode_i, operand_a_i, operand_b_i with in_valid_i; a
//   transaction completes when in_valid_i is high and in_stall_o is low.
//   Output channel: result_o with out_valid_o; taken when out_stall_i is low.
//   Write the modulus through modulus_we_i / modulus_wdata_i while idle.
//   One item is in work at a time; in_stall_o is high until it finishes.
//   All work runs on one shared modular add/subtract unit:
//     operand reduction    : one bit per cycle, 64 bits per operand
//     add, subtract        : one modular add or subtract after reduction
//     multiply             : shift-and-add over the MOD_BITS multiplier bits
//     divide, power        : square-and-multiply over the exponent bits,
//                            up to 2*MOD_BITS multiplies
//   A modulus below 2 gives a result of 0 without running the reduction.
//   The next transaction is taken only after the result is registered.
//   Reset sets the modulus to 1000000007 and empties the pipeline.
//   A stalled receiver holds the result in the output register; the
//   sequencer then waits with the next result until that register frees.
// ----------------------------------------------------------------------------
module prime_field_modular_alu
  import pfma_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [OPND_W-1:0]   operand_a_i,
  input  logic [OPND_W-1:0]   operand_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RESULT_W-1:0] result_o,
  input  logic                modulus_we_i,
  input  logic [CFG_W-1:0]    modulus_wdata_i
);

  logic [CFG_W-1:0]    modulus_q;
  logic                out_valid_q;
  logic [RESULT_W-1:0] out_res_q;
  logic                out_free;
  pfma_stat_t          stat;
  logic [MOD_BITS-1:0] seq_res;

  // Modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else if (modulus_we_i) begin
      modulus_q <= modulus_wdata_i;
    end
  end

  // Output register is free when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;

  pfma_seq #(
    .MOD_BITS (MOD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .modulus_i   (modulus_q[MOD_BITS-1:0]),
    .out_free_i  (out_free),
    .stat_o      (stat),
    .result_o    (seq_res)
  );

  // Output valid: set on a finished result, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (stat.done && out_free) begin
      out_res_q <= RESULT_W'(seq_res);
    end
  end

  assign in_stall_o  = !stat.ready;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_res_q;

endmodule
